### rtl/core/interference_graph_register_picker_unit_assert.svh
// Assertion macros for the register picker
`ifndef INTERFERENCE_GRAPH_REGISTER_PICKER_UNIT_ASSERT_SVH
`define INTERFERENCE_GRAPH_REGISTER_PICKER_UNIT_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define IGRP_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication whose consequent is checked in the next cycle
`define IGRP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### rtl/core/igrp_pkg.sv
// Shared types and constants of the register picker
package igrp_pkg;
    localparam int NUM_VARS = 64;
    localparam int REG_COUNT = 64;
    localparam int VW = $clog2(NUM_VARS);
    localparam logic [1:0] REQ_UPDATE = 2'd0;
    localparam logic [1:0] REQ_ALLOC  = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;
    localparam logic [1:0] REQ_NONE   = 2'd3;
    localparam logic [1:0] TAG_A = 2'd1;
    localparam logic [1:0] TAG_B = 2'd2;
    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] live_out_mask;
        logic [63:0] def_mask;
        logic [5:0]  var_index;
        logic [1:0]  reg_tag;
        logic [5:0]  reg_number;
        logic        flag_on_empty;
    } cmd_t;
endpackage

### rtl/core/igrp_front.sv
// Front end: accepts words, drops REQ_NONE requests, queues commands
module igrp_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  igrp_pkg::cmd_t  s_cmd,
    output logic            q_valid,
    input  logic            q_ready,
    output igrp_pkg::cmd_t  q_cmd
);
    import igrp_pkg::*;
    cmd_t       slot_reg [QDEPTH];
    logic [1:0] cnt_reg, cnt_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    logic       push, pop;

    assign s_ready = (cnt_reg != 2'(QDEPTH));
    assign push = s_valid && s_ready && (s_cmd.req_type != REQ_NONE);
    assign q_valid = (cnt_reg != 2'd0);
    assign pop = q_valid && q_ready;
    assign q_cmd = slot_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
        end
        if (push) slot_reg[wr_ptr_reg] <= s_cmd;
    end
endmodule

### rtl/core/igrp_back.sv
// Back end: interference matrix, allocation table and query scan
module igrp_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    output logic            q_ready,
    input  igrp_pkg::cmd_t  q_cmd,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [63:0]     m_free_mask,
    output logic            m_found,
    output logic [5:0]      m_chosen_reg,
    output logic            m_alloc_failed
);
    import igrp_pkg::*;
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_UPD  = 3'd1;
    localparam logic [2:0] ST_QROW = 3'd2;
    localparam logic [2:0] ST_QRY  = 3'd3;
    localparam logic [2:0] ST_PICK = 3'd4;

    logic [2:0]          st_reg;
    cmd_t                cmd_reg;
    logic [VW:0]         cnt_reg;
    logic [VW:0]         cnt_m1;
    logic [VW-1:0]       dx;
    logic [NUM_VARS-1:0] row_vld_reg, alloc_vld_reg;
    logic [63:0]         row_reg, freem_reg;
    logic [63:0]         nb, row_old, row_add, bit_d;
    logic                take;
    logic                rw_rd_en, rw_wr_en, al_rd_en, al_wr_en;
    logic [VW-1:0]       rw_rd_addr;
    logic [63:0]         rw_rd_data;
    logic [7:0]          al_rd_data;
    logic                out_v_reg;
    logic [5:0]          pick_reg;
    logic                pfound_reg;

    assign take    = q_valid && q_ready;
    assign cnt_m1  = cnt_reg - 1'b1;
    // row or table entry whose read data is present this cycle
    assign dx      = cnt_m1[VW-1:0];
    assign bit_d   = 64'd1 << dx;
    assign nb      = cmd_reg.live_out_mask | cmd_reg.def_mask;
    assign row_old = row_vld_reg[dx] ? rw_rd_data : '0;
    assign row_add = cmd_reg.live_out_mask[dx] ? (nb & ~bit_d) :
                     cmd_reg.def_mask[dx] ? (cmd_reg.live_out_mask & ~bit_d) : '0;

    assign rw_rd_en   = (st_reg == ST_IDLE) ? (take && q_cmd.req_type == REQ_QUERY)
                                            : (st_reg == ST_UPD && !cnt_reg[VW]);
    assign rw_rd_addr = (st_reg == ST_IDLE) ? q_cmd.var_index[VW-1:0] : cnt_reg[VW-1:0];
    assign rw_wr_en   = (st_reg == ST_UPD) && (cnt_reg != '0) &&
                        (cmd_reg.live_out_mask[dx] || cmd_reg.def_mask[dx]);
    assign al_wr_en   = take && q_cmd.req_type == REQ_ALLOC;
    assign al_rd_en   = (st_reg == ST_QRY) && !cnt_reg[VW];

    assign q_ready = (st_reg == ST_IDLE) && !out_v_reg;
    assign m_valid = out_v_reg;
    assign m_free_mask = freem_reg;
    assign m_found = pfound_reg;
    assign m_chosen_reg = pick_reg;
    assign m_alloc_failed = cmd_reg.flag_on_empty && !pfound_reg;

    igrp_ram #(.WIDTH(NUM_VARS), .DEPTH(NUM_VARS)) u_rows (
        .clk     (aclk),
        .wr_en   (rw_wr_en),
        .wr_addr (dx),
        .wr_data (row_old | row_add),
        .rd_en   (rw_rd_en),
        .rd_addr (rw_rd_addr),
        .rd_data (rw_rd_data)
    );

    igrp_ram #(.WIDTH(8), .DEPTH(NUM_VARS)) u_alloc (
        .clk     (aclk),
        .wr_en   (al_wr_en),
        .wr_addr (q_cmd.var_index[VW-1:0]),
        .wr_data ({q_cmd.reg_number, q_cmd.reg_tag}),
        .rd_en   (al_rd_en),
        .rd_addr (cnt_reg[VW-1:0]),
        .rd_data (al_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_IDLE;
            out_v_reg     <= 1'b0;
            cnt_reg       <= '0;
            row_vld_reg   <= '0;
            alloc_vld_reg <= '0;
        end else begin
            if (m_valid && m_ready) out_v_reg <= 1'b0;
            case (st_reg)
                ST_IDLE: begin
                    if (take) begin
                        cmd_reg <= q_cmd;
                        cnt_reg <= '0;
                        if (q_cmd.req_type == REQ_UPDATE) begin
                            st_reg <= ST_UPD;
                        end else if (q_cmd.req_type == REQ_ALLOC) begin
                            alloc_vld_reg[q_cmd.var_index[VW-1:0]] <= 1'b1;
                        end else begin
                            freem_reg <= '1;
                            st_reg    <= (q_cmd.reg_tag == TAG_A || q_cmd.reg_tag == TAG_B)
                                         ? ST_QROW : ST_PICK;
                        end
                    end
                end
                ST_UPD: begin
                    if (rw_wr_en) row_vld_reg[dx] <= 1'b1;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == (VW+1)'(NUM_VARS)) st_reg <= ST_IDLE;
                end
                ST_QROW: begin
                    row_reg <= row_vld_reg[cmd_reg.var_index[VW-1:0]] ? rw_rd_data : '0;
                    st_reg  <= ST_QRY;
                end
                ST_QRY: begin
                    if (cnt_reg != '0 && row_reg[dx] && alloc_vld_reg[dx] &&
                        al_rd_data[1:0] == cmd_reg.reg_tag)
                        freem_reg[al_rd_data[7:2]] <= 1'b0;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == (VW+1)'(NUM_VARS)) begin
                        st_reg  <= ST_PICK;
                        cnt_reg <= '0;
                    end
                end
                ST_PICK: begin
                    pfound_reg <= |freem_reg;
                    pick_reg   <= '0;
                    for (int r = 63; r >= 0; r--)
                        if (freem_reg[r]) pick_reg <= 6'(r);
                    out_v_reg <= 1'b1;
                    st_reg    <= ST_IDLE;
                end
                default: begin
                    st_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `include "interference_graph_register_picker_unit_assert.svh"
    `IGRP_ASSERT_IMP(a_hold, aclk, aresetn, m_valid && !m_ready, q_ready == 1'b0)
    `IGRP_ASSERT_NEXT(a_pick, aclk, aresetn, st_reg == ST_PICK, m_valid)
    `IGRP_ASSERT_IMP(a_busy, aclk, aresetn, st_reg != ST_IDLE, !q_ready)
endmodule

// Generic simple dual-port RAM with registered read
module igrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) mem_reg[wr_addr] <= wr_data;
        if (rd_en) rd_data_reg <= mem_reg[rd_addr];
    end
endmodule

### rtl/core/interference_graph_register_picker_unit.sv
// A query with tag A or B goes through the row read, the table scan and the pick before its result
// is valid, else straight to the pick. An update walks every row; one row or table entry a cycle.
// An allocation is written as taken; a new word is taken only when idle and no result waits.
// A two-word queue takes input while the back end is busy; a waiting result stalls the back end.
// Synchronous active-low reset empties the queue and clears the row and entry valid bits,
// so the matrix and the allocation table read as cleared once reset is released.
module interference_graph_register_picker_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [63:0] s_live_out_mask,
    input  logic [63:0] s_def_mask,
    input  logic [5:0]  s_var_index,
    input  logic [1:0]  s_reg_tag,
    input  logic [5:0]  s_reg_number,
    input  logic        s_flag_on_empty,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_free_mask,
    output logic        m_found,
    output logic [5:0]  m_chosen_reg,
    output logic        m_alloc_failed
);
    import igrp_pkg::*;
    cmd_t s_cmd, q_cmd;
    logic q_valid, q_ready;

    assign s_cmd = '{s_req_type, s_live_out_mask, s_def_mask, s_var_index,
                     s_reg_tag, s_reg_number, s_flag_on_empty};

    igrp_front u_front (.aclk, .aresetn, .s_valid, .s_ready, .s_cmd,
                        .q_valid, .q_ready, .q_cmd);
    igrp_back u_back (.aclk, .aresetn, .q_valid, .q_ready, .q_cmd,
                      .m_valid, .m_ready, .m_free_mask, .m_found,
                      .m_chosen_reg, .m_alloc_failed);
endmodule

### sim/interference_graph_register_picker_unit_tb.sv
// Self-checking testbench for the interference-graph register picker unit
`timescale 1ns / 1ps
module interference_graph_register_picker_unit_tb;
    import igrp_pkg::*;

    typedef struct {
        logic [63:0] free_mask;
        logic        found;
        logic [5:0]  chosen_reg;
        logic        alloc_failed;
    } pick_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type = REQ_UPDATE;
    logic [63:0] s_live_out_mask = '0;
    logic [63:0] s_def_mask = '0;
    logic [5:0]  s_var_index = '0;
    logic [1:0]  s_reg_tag = '0;
    logic [5:0]  s_reg_number = '0;
    logic        s_flag_on_empty = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_free_mask;
    logic        m_found;
    logic [5:0]  m_chosen_reg;
    logic        m_alloc_failed;

    cmd_t  pending_cmds[$];
    pick_t expected_picks[$];
    logic [63:0] nbr_rows[NUM_VARS];
    logic [1:0]  var_tag[NUM_VARS];
    logic [5:0]  var_reg[NUM_VARS];
    int    errors = 0;
    bit    quiet_run = 1'b0;
    bit    hold_phase = 1'b0;
    int    hold_count = 0;

    interference_graph_register_picker_unit DUT (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        #100ms;
        $display("interference_graph_register_picker_unit verification failed");
        $finish;
    end

    task automatic apply_cmd(input cmd_t c);
        logic [63:0] lv, df, nb, fm;
        pick_t p;
        if (c.req_type == REQ_UPDATE) begin
            lv = c.live_out_mask;
            df = c.def_mask;
            nb = lv | df;
            for (int x = 0; x < NUM_VARS; x++) begin
                if (lv[x]) nbr_rows[x] |= nb & ~(64'd1 << x);
                if (df[x]) nbr_rows[x] |= lv & ~(64'd1 << x);
            end
        end else if (c.req_type == REQ_ALLOC) begin
            var_tag[c.var_index] = c.reg_tag;
            var_reg[c.var_index] = c.reg_number;
        end else if (c.req_type == REQ_QUERY) begin
            fm = '1;
            if (c.reg_tag == TAG_A || c.reg_tag == TAG_B)
                for (int j = 0; j < NUM_VARS; j++)
                    if (nbr_rows[c.var_index][j] && var_tag[j] == c.reg_tag)
                        fm[var_reg[j]] = 1'b0;
            p.free_mask = fm;
            p.found = |fm;
            p.chosen_reg = '0;
            for (int r = REG_COUNT - 1; r >= 0; r--)
                if (fm[r]) p.chosen_reg = r[5:0];
            p.alloc_failed = c.flag_on_empty && !p.found;
            expected_picks.push_back(p);
        end
    endtask

    function automatic cmd_t rand_cmd(input logic [1:0] kind);
        cmd_t c;
        c.req_type = kind;
        c.live_out_mask = {$urandom, $urandom};
        c.def_mask = {$urandom, $urandom};
        if ($urandom_range(0, 2) == 0) c.live_out_mask &= {$urandom, $urandom};
        if ($urandom_range(0, 1) == 0) c.def_mask &= {$urandom, $urandom} & {$urandom, $urandom};
        c.var_index = 6'($urandom_range(0, 63));
        c.reg_tag = 2'($urandom_range(0, 3));
        c.reg_number = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                    : 6'($urandom_range(0, 7));
        c.flag_on_empty = 1'($urandom_range(0, 1));
        return c;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_ready) begin
                if (pending_cmds.size() != 0 && (quiet_run || $urandom_range(0, 99) >= 21)) begin
                    cmd_t c;
                    c = pending_cmds.pop_front();
                    apply_cmd(c);
                    s_valid <= 1'b1;
                    s_req_type <= c.req_type;
                    s_live_out_mask <= c.live_out_mask;
                    s_def_mask <= c.def_mask;
                    s_var_index <= c.var_index;
                    s_reg_tag <= c.reg_tag;
                    s_reg_number <= c.reg_number;
                    s_flag_on_empty <= c.flag_on_empty;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall
    always @(posedge aclk) begin
        if (hold_phase) begin
            hold_count <= hold_count + 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= quiet_run || $urandom_range(0, 99) >= 21;
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_picks.size() == 0) begin
                $display("%0t: free_mask exp none got %h", $time, m_free_mask);
                errors++;
            end else begin
                pick_t e;
                e = expected_picks.pop_front();
                if (m_free_mask !== e.free_mask) begin
                    $display("%0t: free_mask exp %h got %h", $time, e.free_mask, m_free_mask);
                    errors++;
                end
                if (m_found !== e.found) begin
                    $display("%0t: found exp %b got %b", $time, e.found, m_found);
                    errors++;
                end
                if (m_chosen_reg !== e.chosen_reg) begin
                    $display("%0t: chosen_reg exp %0d got %0d", $time, e.chosen_reg,
                             m_chosen_reg);
                    errors++;
                end
                if (m_alloc_failed !== e.alloc_failed) begin
                    $display("%0t: alloc_failed exp %b got %b", $time, e.alloc_failed,
                             m_alloc_failed);
                    errors++;
                end
            end
        end
    end

    initial begin
        cmd_t c;
        for (int i = 0; i < NUM_VARS; i++) begin
            nbr_rows[i] = '0;
            var_tag[i] = '0;
            var_reg[i] = '0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed
        c = rand_cmd(REQ_QUERY); c.var_index = '0; c.reg_tag = TAG_A; c.flag_on_empty = 1'b1;
        pending_cmds.push_back(c);
        c = rand_cmd(REQ_UPDATE); c.live_out_mask = '1; c.def_mask = '1;
        pending_cmds.push_back(c);
        c = rand_cmd(REQ_UPDATE); c.live_out_mask = '0; c.def_mask = '0;
        pending_cmds.push_back(c);
        for (int v = 1; v < NUM_VARS; v++) begin
            c = rand_cmd(REQ_ALLOC); c.var_index = 6'(v); c.reg_tag = TAG_A;
            c.reg_number = 6'(v);
            if (v > 62 || v < 20) pending_cmds.push_back(c);
        end
        c = rand_cmd(REQ_ALLOC); c.var_index = 6'd63; c.reg_tag = TAG_B; c.reg_number = 6'd63;
        pending_cmds.push_back(c);
        c = rand_cmd(REQ_NONE); pending_cmds.push_back(c);
        for (int t = 0; t < 4; t++) begin
            c = rand_cmd(REQ_QUERY); c.var_index = '0; c.reg_tag = 2'(t);
            c.flag_on_empty = 1'b1;
            pending_cmds.push_back(c);
        end
        c = rand_cmd(REQ_QUERY); c.var_index = 6'd63; c.reg_tag = TAG_B; c.flag_on_empty = 1'b0;
        pending_cmds.push_back(c);

        // random with a quiet stretch and a long receiver hold
        for (int n = 0; n < 450; n++) begin
            int k;
            k = $urandom_range(0, 99);
            c = rand_cmd(k < 25 ? REQ_UPDATE : k < 60 ? REQ_ALLOC : k < 97 ? REQ_QUERY : REQ_NONE);
            pending_cmds.push_back(c);
            if (n == 150) begin
                while (pending_cmds.size() > 0) @(posedge aclk);
                quiet_run = 1'b1;
            end
            if (n == 220) begin
                while (pending_cmds.size() > 0) @(posedge aclk);
                quiet_run = 1'b0;
                hold_phase = 1'b1;
            end
            if (n == 240) begin
                while (pending_cmds.size() > 0 && hold_count < 2000) @(posedge aclk);
                while (hold_count < 2000) @(posedge aclk);
                hold_phase = 1'b0;
            end
        end
        while (pending_cmds.size() > 0 || (s_valid && !s_ready)) @(posedge aclk);
        @(posedge aclk);
        while (expected_picks.size() > 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("interference_graph_register_picker_unit verification clean");
        end else begin
            $display("interference_graph_register_picker_unit verification failed");
        end
        $finish;
    end
endmodule
